FILE: rtl/caam_pkg.sv
// Package: shared constants, types and the adder-cell mode codes of the approximate multiplier.
package caam_pkg;

  // Array geometry
  localparam int unsigned OPERAND_WIDTH = 8;
  localparam int unsigned ROWS          = OPERAND_WIDTH - 1;
  localparam int unsigned MODE_BITS     = 4;
  localparam int unsigned ROW_MODE_BITS = OPERAND_WIDTH * MODE_BITS;

  // Fixed port widths
  localparam int unsigned IN_WIDTH      = 8;
  localparam int unsigned PRODUCT_WIDTH = 16;
  localparam int unsigned ADDR_WIDTH    = 5;
  localparam int unsigned DATA_WIDTH    = 64;
  localparam int unsigned ALL_MODE_BITS = 3 * DATA_WIDTH + 32;

  typedef logic [PRODUCT_WIDTH-1:0] product_t;

  // Register indexes (address bits [4:3])
  localparam logic [1:0] REG_MODES_0 = 2'd0;
  localparam logic [1:0] REG_MODES_1 = 2'd1;
  localparam logic [1:0] REG_MODES_2 = 2'd2;
  localparam logic [1:0] REG_MODES_3 = 2'd3;

  // Cell modes; codes not listed are exact full adders
  localparam logic [3:0] MODE_CO_PASS  = 4'd1;
  localparam logic [3:0] MODE_SUM_OR   = 4'd2;
  localparam logic [3:0] MODE_SUM_NCO  = 4'd3;
  localparam logic [3:0] MODE_APPROX5  = 4'd5;
  localparam logic [3:0] MODE_APPROX6  = 4'd6;
  localparam logic [3:0] MODE_APPROX7  = 4'd7;
  localparam logic [3:0] MODE_APPROX8  = 4'd8;
  localparam logic [3:0] MODE_APPROX9  = 4'd9;
  localparam logic [3:0] MODE_AXA1     = 4'd10;
  localparam logic [3:0] MODE_AXA2     = 4'd11;

  // Data handed from one row stage to the next
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] a_rem;  // multiplicand, shifted so bit 1 feeds the next row
    logic [OPERAND_WIDTH-1:0] b;      // multiplier value
    logic [OPERAND_WIDTH-1:0] sums;   // sum outputs of the last row done
    logic                     top;    // carry out of the last row done
    logic [OPERAND_WIDTH-1:0] low;    // low product bits, filled from the top
  } row_t;

endpackage

FILE: rtl/caam_cell.sv
// Single configurable adder cell: partial-product AND plus exact or approximate full add.
module caam_cell (
  input  logic [3:0] mode,
  input  logic       a_bit,
  input  logic       b_bit,
  input  logic       d,
  input  logic       ci,
  output logic       s,
  output logic       co
);

  logic p, x, ex_c, ex_s;

  assign p    = a_bit & b_bit;
  assign x    = p ^ d;
  assign ex_c = (p & d) | (ci & x);
  assign ex_s = x ^ ci;

  // Mode decode
  always_comb begin
    unique case (mode)
      caam_pkg::MODE_CO_PASS: begin
        s  = ex_s;
        co = ci;
      end
      caam_pkg::MODE_SUM_OR: begin
        s  = x | ci;
        co = ex_c;
      end
      caam_pkg::MODE_SUM_NCO: begin
        s  = ~ex_c;
        co = ex_c;
      end
      caam_pkg::MODE_APPROX5: begin
        s  = ci & ~x;
        co = (ci & x) | (d & (p | (~p & ~ci)));
      end
      caam_pkg::MODE_APPROX6: begin
        s  = (~ci & x) | (~p & ~d);
        co = ex_c;
      end
      caam_pkg::MODE_APPROX7: begin
        s  = ~d & (~p | (p & ~ci));
        co = d | (p & ~d & ci);
      end
      caam_pkg::MODE_APPROX8: begin
        s  = ci & (d | (~p & ~d));
        co = p;
      end
      caam_pkg::MODE_APPROX9: begin
        s  = d;
        co = (d & ~ci) | (p & ~(d ^ ci));
      end
      caam_pkg::MODE_AXA1: begin
        s  = ci;
        co = ~((x & ci) | (~p & ~d));
      end
      caam_pkg::MODE_AXA2: begin
        s  = ~x;
        co = ex_c;
      end
      default: begin
        s  = ex_s;
        co = ex_c;
      end
    endcase
  end

endmodule

FILE: rtl/caam_row.sv
// One row of adder cells with its pipeline register and valid/ready handshake.
module caam_row (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [caam_pkg::ROW_MODE_BITS-1:0]      modes,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  caam_pkg::row_t                          up_data,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output caam_pkg::row_t                          dn_data
);

  localparam int unsigned W = caam_pkg::OPERAND_WIDTH;

  logic [W-1:0]   cur;
  logic [W:0]     carry;
  logic           valid_r;
  caam_pkg::row_t data_r;
  caam_pkg::row_t data_nxt;

  assign carry[0] = 1'b0;

  // Ripple row: d is the sum to the upper left, the row carry in the last column
  for (genvar c = 0; c < W; c++) begin : g_cell
    logic d_in;
    if (c + 1 < W) begin : g_mid
      assign d_in = up_data.sums[c+1];
    end else begin : g_last
      assign d_in = up_data.top;
    end
    caam_cell u_cell (
      .mode  (modes[c*caam_pkg::MODE_BITS +: caam_pkg::MODE_BITS]),
      .a_bit (up_data.a_rem[1]),
      .b_bit (up_data.b[c]),
      .d     (d_in),
      .ci    (carry[c]),
      .s     (cur[c]),
      .co    (carry[c+1])
    );
  end

  // Next stage contents
  always_comb begin
    data_nxt.a_rem = {1'b0, up_data.a_rem[W-1:1]};
    data_nxt.b     = up_data.b;
    data_nxt.sums  = cur;
    data_nxt.top   = carry[W];
    data_nxt.low   = {cur[0], up_data.low[W-1:1]};
  end

  assign up_ready = ~valid_r | dn_ready;

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: rtl/configurable_approx_array_multiplier_top.sv
// Top level: mode registers, APB-style port and the chain of row stages.
// Each input transaction passes through every registered row stage on its way to out_valid.
// Throughput: one transaction per cycle while out_ready holds; each row of cells is one pipeline stage.
// A stalled output holds only the stages behind it that are full.
// Reset (synchronous, rst_n low): stage valids cleared, all cell modes zero (exact).
module configurable_approx_array_multiplier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [caam_pkg::IN_WIDTH-1:0]       in_multiplicand,
  input  logic [caam_pkg::IN_WIDTH-1:0]       in_multiplier_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [caam_pkg::PRODUCT_WIDTH-1:0]  out_product,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [caam_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [caam_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [caam_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned W    = caam_pkg::OPERAND_WIDTH;
  localparam int unsigned ROWS = caam_pkg::ROWS;

  logic [caam_pkg::DATA_WIDTH-1:0]    mode0_r, mode1_r, mode2_r;
  logic [31:0]                        mode3_r;
  logic [caam_pkg::ALL_MODE_BITS-1:0] modes_all;
  logic                               wr_en;
  logic [1:0]                         reg_idx;

  caam_pkg::row_t link_data [0:ROWS];
  logic [ROWS:0]  link_valid;
  logic [ROWS:0]  link_ready;
  logic [W-1:0]   pp0;
  logic [2*W-1:0] product_full;

  // Configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode0_r <= '0;
      mode1_r <= '0;
      mode2_r <= '0;
      mode3_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        caam_pkg::REG_MODES_0: mode0_r <= pwdata;
        caam_pkg::REG_MODES_1: mode1_r <= pwdata;
        caam_pkg::REG_MODES_2: mode2_r <= pwdata;
        caam_pkg::REG_MODES_3: mode3_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      caam_pkg::REG_MODES_0: prdata = mode0_r;
      caam_pkg::REG_MODES_1: prdata = mode1_r;
      caam_pkg::REG_MODES_2: prdata = mode2_r;
      caam_pkg::REG_MODES_3: prdata = {32'd0, mode3_r};
      default:               prdata = '0;
    endcase
  end

  assign modes_all = {mode3_r, mode2_r, mode1_r, mode0_r};

  // Top row of partial products enters the chain with the operands
  assign pp0 = {W{in_multiplicand[0]}} & in_multiplier_value[W-1:0];

  always_comb begin
    link_data[0].a_rem = in_multiplicand[W-1:0];
    link_data[0].b     = in_multiplier_value[W-1:0];
    link_data[0].sums  = pp0;
    link_data[0].top   = 1'b0;
    link_data[0].low   = {pp0[0], {(W-1){1'b0}}};
  end

  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];

  // Chain of adder rows
  for (genvar k = 0; k < ROWS; k++) begin : g_row
    caam_row u_row (
      .clk      (clk),
      .rst_n    (rst_n),
      .modes    (modes_all[k*caam_pkg::ROW_MODE_BITS +: caam_pkg::ROW_MODE_BITS]),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  // Product assembly from the last stage
  assign link_ready[ROWS] = out_ready;
  assign out_valid        = link_valid[ROWS];
  assign product_full     = {link_data[ROWS].top, link_data[ROWS].sums[W-1:1],
                             link_data[ROWS].low};
  assign out_product      = caam_pkg::product_t'(product_full);

  // Input can only be held off when every stage is full and the output stalls
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&link_valid[ROWS:1]) && !out_ready))
    else $error("input stalled with room in the row chain");

  // An accepted transaction occupies the first row stage on the next cycle
  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> link_valid[1])
    else $error("accepted transaction lost at the first row");

  // A write to the first mode register lands on the next cycle
  a_mode0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && reg_idx == caam_pkg::REG_MODES_0) |=> (mode0_r == $past(pwdata)))
    else $error("mode register write not taken");

endmodule

FILE: test/caam_product_checker.sv
// Checker: watches the operand, product and register ports, predicts each product and compares.
module caam_product_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [caam_pkg::IN_WIDTH-1:0]      in_multiplicand,
  input  logic [caam_pkg::IN_WIDTH-1:0]      in_multiplier_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [caam_pkg::PRODUCT_WIDTH-1:0] out_product,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [caam_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [caam_pkg::DATA_WIDTH-1:0]    pwdata,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = caam_pkg::OPERAND_WIDTH;

  // Shadow copy of the four mode registers
  logic [3:0][63:0]   mode_shadow;
  caam_pkg::product_t expected_products[$];
  caam_pkg::product_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    mode_shadow = '0;
  end

  // One adder cell: returns {carry, sum}
  function automatic logic [1:0] cell_eval(input logic [3:0] mode, input logic p,
                                           input logic d, input logic ci);
    logic x, ex_s, ex_c, s, co;
    x    = p ^ d;
    ex_s = x ^ ci;
    ex_c = (p & d) | (ci & x);
    s    = ex_s;
    co   = ex_c;
    case (mode)
      caam_pkg::MODE_CO_PASS: co = ci;
      caam_pkg::MODE_SUM_OR:  s = x | ci;
      caam_pkg::MODE_SUM_NCO: s = ~ex_c;
      caam_pkg::MODE_APPROX5: begin
        s  = ci & ~x;
        co = (ci & x) | (d & (p | (~p & ~ci)));
      end
      caam_pkg::MODE_APPROX6: s = (~ci & x) | (~p & ~d);
      caam_pkg::MODE_APPROX7: begin
        s  = ~d & (~p | (p & ~ci));
        co = d | (p & ~d & ci);
      end
      caam_pkg::MODE_APPROX8: begin
        s  = ci & (d | (~p & ~d));
        co = p;
      end
      caam_pkg::MODE_APPROX9: begin
        s  = d;
        co = (d & ~ci) | (p & ~(d ^ ci));
      end
      caam_pkg::MODE_AXA1: begin
        s  = ci;
        co = ~((x & ci) | (~p & ~d));
      end
      caam_pkg::MODE_AXA2: s = ~x;
      default: ;
    endcase
    return {co, s};
  endfunction

  // Ripple the operands through the array of cells row by row
  function automatic caam_pkg::product_t approx_product(input logic [W-1:0] a,
                                                        input logic [W-1:0] b,
                                                        input logic [3:0][63:0] regs);
    logic [W-1:0] upper, row_sum;
    logic top, carry, p, d, ci;
    logic [1:0] sc;
    logic [3:0] mode;
    int cell_idx;
    caam_pkg::product_t prod;
    prod  = '0;
    top   = 1'b0;
    upper = a[0] ? b : '0;
    prod[0] = upper[0];
    for (int r = 1; r < W; r++) begin
      carry = 1'b0;
      for (int c = 0; c < W; c++) begin
        p    = a[r] & b[c];
        d    = (c + 1 < W) ? upper[c+1] : top;
        ci   = (c == 0) ? 1'b0 : carry;
        cell_idx = (r - 1) * W + c;
        mode = regs[cell_idx / 16][(cell_idx % 16) * 4 +: 4];
        sc   = cell_eval(mode, p, d, ci);
        row_sum[c] = sc[0];
        carry      = sc[1];
      end
      top   = carry;
      upper = row_sum;
      prod[r] = row_sum[0];
    end
    for (int c = 1; c < W; c++)
      prod[W - 1 + c] = upper[c];
    prod[2 * W - 1] = top;
    return prod;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns product check: %s", $time, what);
    fail_count++;
  endtask

  // Track operand transactions, product transactions and register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_shadow = '0;
      expected_products.delete();
    end else begin
      if (in_valid && in_ready)
        expected_products.insert(expected_products.size(),
                                 approx_product(in_multiplicand, in_multiplier_value,
                                                mode_shadow));
      if (out_valid && out_ready) begin
        if (expected_products.size() == 0) begin
          report_mismatch($sformatf("product %h with no transaction waiting", out_product));
        end else begin
          want = expected_products.pop_front();
          if (out_product !== want)
            report_mismatch($sformatf("product %h, predicted %h", out_product, want));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3]) inside
          caam_pkg::REG_MODES_0, caam_pkg::REG_MODES_1, caam_pkg::REG_MODES_2:
            mode_shadow[paddr[4:3]] = pwdata;
          caam_pkg::REG_MODES_3:
            mode_shadow[caam_pkg::REG_MODES_3] = {32'b0, pwdata[31:0]};
          default: ;
        endcase
      end
    end
    pending = expected_products.size();
  end

endmodule

FILE: test/tb_configurable_approx_array_multiplier_top.sv
// Testbench top: clock, reset, operand and register stimulus, ready pattern and verdict.
module tb_configurable_approx_array_multiplier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = caam_pkg::ROWS;
  localparam int PHASES       = 20;
  localparam int PHASE_ITEMS  = 22;
  localparam int IN_W         = caam_pkg::IN_WIDTH;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [caam_pkg::IN_WIDTH-1:0]      in_multiplicand = '0;
  logic [caam_pkg::IN_WIDTH-1:0]      in_multiplier_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [caam_pkg::PRODUCT_WIDTH-1:0] out_product;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [caam_pkg::ADDR_WIDTH-1:0]    paddr = '0;
  logic [caam_pkg::DATA_WIDTH-1:0]    pwdata = '0;
  logic [caam_pkg::DATA_WIDTH-1:0]    prdata;
  logic                               pready;

  int fail_count;
  int pending;

  // Idle percentages and the long receiver hold-off request
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  logic [63:0] reg_value;
  logic [3:0]  uniform_mode;

  always #6 clk = ~clk;

  configurable_approx_array_multiplier_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_multiplicand     (in_multiplicand),
    .in_multiplier_value (in_multiplier_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_product         (out_product),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  caam_product_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_multiplicand     (in_multiplicand),
    .in_multiplier_value (in_multiplier_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_product         (out_product),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .pready              (pready),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // Receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Setup cycle, then access cycle; the write lands when pready is seen
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Bus returns to idle before the next write
    @(posedge clk);
  endtask

  // Offer one operand pair, hold until accepted, then maybe idle
  task automatic send_item(input logic [caam_pkg::IN_WIDTH-1:0] a,
                           input logic [caam_pkg::IN_WIDTH-1:0] b);
    int gap;
    gap = 0;
    in_valid            <= 1'b1;
    in_multiplicand     <= a;
    in_multiplier_value <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted product has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [caam_pkg::IN_WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Main stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed operand extremes with all cells exact after reset
    send_item(8'h00, 8'h00);
    send_item(8'hFF, 8'hFF);
    send_item(8'hFF, 8'h00);
    send_item(8'h00, 8'hFF);
    send_item(8'h01, 8'h01);
    send_item(8'h80, 8'h80);
    send_item(8'hFF, 8'h01);
    send_item(8'h01, 8'hFF);
    send_item(8'hAA, 8'h55);
    send_item(8'h55, 8'hAA);
    send_item(8'h80, 8'hFF);
    send_item(8'hFF, 8'h80);
    drain();

    // Phases: zero modes, all-ones, each mode everywhere, then random mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 63; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 63; end
        default: begin snd_idle_pct = 25; rcv_stall_pct = 25; end
      endcase
      uniform_mode = 4'(ph - 1);
      for (int k = 0; k < 4; k++) begin
        if (ph == 0) begin
          reg_value = '0;
        end else if (ph == 1) begin
          reg_value = '1;
        end else if (ph <= 12) begin
          reg_value = {16{uniform_mode}};
        end else if (ph % 2 == 1) begin
          reg_value = {$urandom, $urandom};
        end else begin
          for (int j = 0; j < 16; j++)
            reg_value[4*j +: 4] = 4'($urandom_range(1, 11));
        end
        cfg_write(2'(k), reg_value);
      end
      // Long output hold-off so the pipeline fills and stalls the input
      if (ph == 4) hold_req = 150;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 9 && n == PHASE_ITEMS / 2) drain();
        send_item(pick_operand(), pick_operand());
      end
      drain();
    end

    repeat (PIPE_LATENCY * 3) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("configurable_approx_array_multiplier_top: match");
    end else begin
      $display("configurable_approx_array_multiplier_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(300_000 * 12);
    $display("configurable_approx_array_multiplier_top: mismatch");
    $finish;
  end

endmodule
